// ===== sv/prts_pkg.sv =====
// Package for the push-rod tap sequencer: phase codes, register indexes,
// configuration and result structs. No dependencies.
`default_nettype none

package prts_pkg;

	localparam int unsigned EXT_W = 24;
	localparam int unsigned DUR_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = EXT_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXTEND_TIMEOUT     = 3'd0,
		REG_CONTACT_HOLD       = 3'd1,
		REG_BRAKE_TIME         = 3'd2,
		REG_RETRACT_TIME       = 3'd3,
		REG_ABORT_RETRACT_TIME = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_EXTEND  = 3'd1,
		PH_HOLD    = 3'd2,
		PH_BRAKE   = 3'd3,
		PH_RETRACT = 3'd4
	} phase_t;

	localparam logic [EXT_W-1:0] RST_EXTEND_TIMEOUT     = 24'd5000;
	localparam logic [DUR_W-1:0] RST_CONTACT_HOLD       = 16'd20;
	localparam logic [DUR_W-1:0] RST_BRAKE_TIME         = 16'd50;
	localparam logic [DUR_W-1:0] RST_RETRACT_TIME       = 16'd2000;
	localparam logic [DUR_W-1:0] RST_ABORT_RETRACT_TIME = 16'd5000;

	typedef struct packed {
		logic [EXT_W-1:0] extend_timeout;
		logic [DUR_W-1:0] contact_hold;
		logic [DUR_W-1:0] brake_time;
		logic [DUR_W-1:0] retract_time;
		logic [DUR_W-1:0] abort_retract_time;
	} cfg_t;

	typedef struct packed {
		logic drive_a;
		logic drive_b;
		logic busy_res;
		logic done_res;
		logic succeeded;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/prts_if.sv =====
// Valid/ready channel interfaces for the tap sequencer: input tick beats and
// result beats. No dependencies.
`default_nettype none

interface prts_in_if;
	logic valid;
	logic ready;
	logic start_req;
	logic detect_level;

	modport source (output valid, output start_req, output detect_level, input ready);
	modport sink (input valid, input start_req, input detect_level, output ready);
endinterface

interface prts_out_if;
	logic valid;
	logic ready;
	logic drive_a;
	logic drive_b;
	logic busy_res;
	logic done_res;
	logic succeeded;

	modport source (output valid, output drive_a, output drive_b, output busy_res,
		output done_res, output succeeded, input ready);
	modport sink (input valid, input drive_a, input drive_b, input busy_res,
		input done_res, input succeeded, output ready);
endinterface

`default_nettype wire

// ===== sv/push_rod_tap_sequencer.sv =====
// Top level of the push-rod tap sequencer: config registers, sequencer
// state, tick logic and the result register. Depends on prts_pkg, prts_if,
// prts_cfg_regs and prts_step.
// Usage: every input beat on in_ch is one time tick carrying start_req and
// the contact switch level (0 = closed). Every accepted beat yields exactly
// one result beat on out_ch with the motor pins, busy, a one-tick done pulse
// and the success flag, all showing the state after that tick.
// The result of a beat is registered: it is valid right after the edge that
// accepts the beat. Throughput is one beat per cycle while out_ch is ready;
// the phase and counter update is a single pass of logic between the state
// registers and the result register.
// in_ch.ready is high whenever the result register is empty or being taken,
// so a stalled receiver holds the result and stops input after one beat.
// Reset clears the phase to idle, the counter and outcome to zero, and loads
// the register defaults. Write config through cfg_we/cfg_index/cfg_wdata
// only while no tap is in progress.
`default_nettype none

module push_rod_tap_sequencer #(
	parameter int unsigned TIMER_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [prts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [prts_pkg::CFG_DATA_W-1:0] cfg_wdata,
	prts_in_if.sink                              in_ch,
	prts_out_if.source                           out_ch
);

	prts_pkg::cfg_t        cfg;
	prts_pkg::phase_t      phase_q;
	logic [TIMER_BITS-1:0] cnt_q;
	logic                  outcome_q;
	prts_pkg::phase_t      nxt_phase;
	logic [TIMER_BITS-1:0] nxt_cnt;
	logic                  nxt_outcome;
	prts_pkg::res_t        res;
	prts_pkg::res_t        res_s1;
	logic                  valid_s1;
	logic                  accept;

	prts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	prts_step #(.TIMER_BITS(TIMER_BITS)) u_step (
		.phase        (phase_q),
		.cnt          (cnt_q),
		.outcome      (outcome_q),
		.start_req    (in_ch.start_req),
		.detect_level (in_ch.detect_level),
		.cfg          (cfg),
		.nxt_phase    (nxt_phase),
		.nxt_cnt      (nxt_cnt),
		.nxt_outcome  (nxt_outcome),
		.res          (res)
	);

	assign in_ch.ready = !valid_s1 || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= prts_pkg::PH_IDLE;
			cnt_q     <= '0;
			outcome_q <= 1'b0;
			valid_s1  <= 1'b0;
		end else if (accept) begin
			phase_q   <= nxt_phase;
			cnt_q     <= nxt_cnt;
			outcome_q <= nxt_outcome;
			valid_s1  <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s1  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign out_ch.valid     = valid_s1;
	assign out_ch.drive_a   = res_s1.drive_a;
	assign out_ch.drive_b   = res_s1.drive_b;
	assign out_ch.busy_res  = res_s1.busy_res;
	assign out_ch.done_res  = res_s1.done_res;
	assign out_ch.succeeded = res_s1.succeeded;

endmodule

`default_nettype wire

// ===== sv/prts_cfg_regs.sv =====
// Configuration register file of the tap sequencer.
// Depends on prts_pkg.
`default_nettype none

module prts_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [prts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [prts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output prts_pkg::cfg_t                          cfg
);

	prts_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.extend_timeout     <= prts_pkg::RST_EXTEND_TIMEOUT;
			cfg_q.contact_hold       <= prts_pkg::RST_CONTACT_HOLD;
			cfg_q.brake_time         <= prts_pkg::RST_BRAKE_TIME;
			cfg_q.retract_time       <= prts_pkg::RST_RETRACT_TIME;
			cfg_q.abort_retract_time <= prts_pkg::RST_ABORT_RETRACT_TIME;
		end else if (cfg_we) begin
			case (cfg_index)
				prts_pkg::REG_EXTEND_TIMEOUT:
					cfg_q.extend_timeout <= cfg_wdata[prts_pkg::EXT_W-1:0];
				prts_pkg::REG_CONTACT_HOLD:
					cfg_q.contact_hold <= cfg_wdata[prts_pkg::DUR_W-1:0];
				prts_pkg::REG_BRAKE_TIME:
					cfg_q.brake_time <= cfg_wdata[prts_pkg::DUR_W-1:0];
				prts_pkg::REG_RETRACT_TIME:
					cfg_q.retract_time <= cfg_wdata[prts_pkg::DUR_W-1:0];
				prts_pkg::REG_ABORT_RETRACT_TIME:
					cfg_q.abort_retract_time <= cfg_wdata[prts_pkg::DUR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/prts_step.sv =====
// Next-state and result logic for one tick of the tap sequencer.
// Depends on prts_pkg.
`default_nettype none

module prts_step #(
	parameter int unsigned TIMER_BITS = 24
) (
	input  wire prts_pkg::phase_t   phase,
	input  wire logic [TIMER_BITS-1:0] cnt,
	input  wire logic               outcome,
	input  wire logic               start_req,
	input  wire logic               detect_level,
	input  wire prts_pkg::cfg_t     cfg,
	output prts_pkg::phase_t        nxt_phase,
	output logic [TIMER_BITS-1:0]   nxt_cnt,
	output logic                    nxt_outcome,
	output prts_pkg::res_t          res
);

	localparam int unsigned CMP_W = 33;

	logic [TIMER_BITS-1:0] dec;
	logic [TIMER_BITS-1:0] ret_dur;
	logic                  enter;
	logic [2:0]            from_ph;
	logic                  done;
	prts_pkg::phase_t      mid_phase;
	logic [TIMER_BITS-1:0] mid_cnt;
	logic                  timed_out;

	assign dec = (cnt != '0) ? cnt - TIMER_BITS'(1) : cnt;
	assign timed_out = CMP_W'(cnt) >= CMP_W'(cfg.extend_timeout);

	always_comb begin
		mid_phase   = phase;
		mid_cnt     = cnt;
		nxt_outcome = outcome;
		enter       = 1'b0;
		from_ph     = prts_pkg::PH_HOLD;
		case (phase)
			prts_pkg::PH_IDLE: begin
				if (start_req) begin
					mid_phase = prts_pkg::PH_EXTEND;
					mid_cnt   = '0;
				end
			end
			prts_pkg::PH_EXTEND: begin
				if (!detect_level) begin
					nxt_outcome = 1'b1;
					enter       = 1'b1;
					from_ph     = prts_pkg::PH_HOLD;
				end else if (timed_out) begin
					nxt_outcome = 1'b0;
					enter       = 1'b1;
					from_ph     = prts_pkg::PH_BRAKE;
				end else if (cnt != '1) begin
					mid_cnt = cnt + TIMER_BITS'(1);
				end
			end
			prts_pkg::PH_HOLD, prts_pkg::PH_BRAKE, prts_pkg::PH_RETRACT: begin
				mid_cnt = dec;
				if (dec == '0) begin
					enter   = 1'b1;
					from_ph = phase + 3'd1;
				end
			end
			default: begin
				mid_phase = prts_pkg::PH_IDLE;
				mid_cnt   = '0;
			end
		endcase
	end

	assign ret_dur = nxt_outcome ? TIMER_BITS'(cfg.retract_time)
		: TIMER_BITS'(cfg.abort_retract_time);

	// skip zero-length phases within the same tick
	always_comb begin
		nxt_phase = mid_phase;
		nxt_cnt   = mid_cnt;
		done      = 1'b0;
		if (enter) begin
			if (from_ph <= prts_pkg::PH_HOLD && cfg.contact_hold != '0) begin
				nxt_phase = prts_pkg::PH_HOLD;
				nxt_cnt   = TIMER_BITS'(cfg.contact_hold);
			end else if (from_ph <= prts_pkg::PH_BRAKE && cfg.brake_time != '0) begin
				nxt_phase = prts_pkg::PH_BRAKE;
				nxt_cnt   = TIMER_BITS'(cfg.brake_time);
			end else if (from_ph <= prts_pkg::PH_RETRACT && ret_dur != '0) begin
				nxt_phase = prts_pkg::PH_RETRACT;
				nxt_cnt   = ret_dur;
			end else begin
				nxt_phase = prts_pkg::PH_IDLE;
				nxt_cnt   = '0;
				done      = 1'b1;
			end
		end
	end

	assign res.drive_a   = (nxt_phase == prts_pkg::PH_EXTEND) || (nxt_phase == prts_pkg::PH_HOLD);
	assign res.drive_b   = (nxt_phase == prts_pkg::PH_RETRACT);
	assign res.busy_res  = (nxt_phase != prts_pkg::PH_IDLE);
	assign res.done_res  = done;
	assign res.succeeded = done & nxt_outcome;

endmodule

`default_nettype wire

// ===== verif/tb_push_rod_tap_sequencer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for push_rod_tap_sequencer: drives tick beats and config writes,
// predicts every result beat with its own phase/timer model and compares field by field.
// Depends on prts_pkg, prts_if and the push_rod_tap_sequencer RTL.

module tb_push_rod_tap_sequencer;

	localparam int unsigned TMR_W = 24;
	localparam int unsigned DATA_W = prts_pkg::CFG_DATA_W;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned HOLD_OFF_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic cfg_we;
	prts_pkg::reg_idx_t cfg_index;
	logic [DATA_W-1:0] cfg_wdata;

	prts_in_if tick_ch ();
	prts_out_if res_ch ();

	push_rod_tap_sequencer #(.TIMER_BITS(TMR_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch(tick_ch),
		.out_ch(res_ch)
	);

	prts_pkg::cfg_t cfg_now;
	prts_pkg::phase_t seq_phase;
	logic [TMR_W-1:0] seq_count;
	logic seq_contact;
	prts_pkg::res_t pending_res[$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_off_seq;
	int unsigned hold_off_seen;
	int unsigned hold_off_left;
	int unsigned cycle_cnt;
	int unsigned err_count;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		err_count++;
	endtask

	// Enter the first timed phase at or after first_ph with a nonzero duration.
	function automatic logic enter_timed(input prts_pkg::phase_t first_ph);
		prts_pkg::phase_t ph;
		logic [TMR_W-1:0] dur;
		ph = first_ph;
		while (ph != prts_pkg::PH_IDLE) begin
			case (ph)
				prts_pkg::PH_HOLD: dur = TMR_W'(cfg_now.contact_hold);
				prts_pkg::PH_BRAKE: dur = TMR_W'(cfg_now.brake_time);
				prts_pkg::PH_RETRACT: dur = seq_contact ? TMR_W'(cfg_now.retract_time)
					: TMR_W'(cfg_now.abort_retract_time);
				default: dur = '0;
			endcase
			if (dur != '0) begin
				seq_phase = ph;
				seq_count = dur;
				return 1'b0;
			end
			ph = (ph == prts_pkg::PH_RETRACT) ? prts_pkg::PH_IDLE
				: prts_pkg::phase_t'(ph + 1);
		end
		seq_phase = prts_pkg::PH_IDLE;
		seq_count = '0;
		return 1'b1;
	endfunction

	function automatic prts_pkg::res_t predict_tick(input logic start, input logic level);
		prts_pkg::res_t r;
		logic done;
		done = 1'b0;
		case (seq_phase)
			prts_pkg::PH_IDLE: begin
				if (start) begin
					seq_phase = prts_pkg::PH_EXTEND;
					seq_count = '0;
				end
			end
			prts_pkg::PH_EXTEND: begin
				if (!level) begin
					seq_contact = 1'b1;
					done = enter_timed(prts_pkg::PH_HOLD);
				end else if (seq_count >= cfg_now.extend_timeout) begin
					seq_contact = 1'b0;
					done = enter_timed(prts_pkg::PH_BRAKE);
				end else if (seq_count != '1) begin
					seq_count = seq_count + TMR_W'(1);
				end
			end
			prts_pkg::PH_HOLD, prts_pkg::PH_BRAKE, prts_pkg::PH_RETRACT: begin
				if (seq_count != '0)
					seq_count = seq_count - TMR_W'(1);
				if (seq_count == '0)
					done = enter_timed((seq_phase == prts_pkg::PH_RETRACT) ? prts_pkg::PH_IDLE
						: prts_pkg::phase_t'(seq_phase + 1));
			end
			default: begin
				seq_phase = prts_pkg::PH_IDLE;
				seq_count = '0;
			end
		endcase
		r.drive_a = (seq_phase == prts_pkg::PH_EXTEND) || (seq_phase == prts_pkg::PH_HOLD);
		r.drive_b = (seq_phase == prts_pkg::PH_RETRACT);
		r.busy_res = (seq_phase != prts_pkg::PH_IDLE);
		r.done_res = done;
		r.succeeded = done & seq_contact;
		return r;
	endfunction

	task automatic send_tick(input logic start, input logic level);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.start_req <= start;
		tick_ch.detect_level <= level;
		do
			@(posedge clk);
		while (!tick_ch.ready);
		pending_res.push_back(predict_tick(start, level));
	endtask

	// Run the current sequence out to idle; start requests are ignored while busy.
	task automatic settle();
		while (seq_phase != prts_pkg::PH_IDLE)
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic quiesce();
		tick_ch.valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input prts_pkg::reg_idx_t idx, input logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic configure(input prts_pkg::cfg_t c);
		settle();
		quiesce();
		write_reg(prts_pkg::REG_EXTEND_TIMEOUT, DATA_W'(c.extend_timeout));
		write_reg(prts_pkg::REG_CONTACT_HOLD, DATA_W'(c.contact_hold));
		write_reg(prts_pkg::REG_BRAKE_TIME, DATA_W'(c.brake_time));
		write_reg(prts_pkg::REG_RETRACT_TIME, DATA_W'(c.retract_time));
		write_reg(prts_pkg::REG_ABORT_RETRACT_TIME, DATA_W'(c.abort_retract_time));
		cfg_we <= 1'b0;
		cfg_now = c;
	endtask

	task automatic test_reset_defaults();
		quiesce();
		write_reg(prts_pkg::REG_RETRACT_TIME, DATA_W'(3));
		cfg_we <= 1'b0;
		cfg_now.retract_time = 16'd3;
		send_tick(1'b1, 1'b1);
		repeat (3) send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		settle();
	endtask

	task automatic test_zero_durations();
		configure('{24'd0, 16'd0, 16'd0, 16'd0, 16'd0});
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
	endtask

	task automatic test_extend_timeout();
		configure('{24'd3, 16'd2, 16'd1, 16'd2, 16'd3});
		send_tick(1'b1, 1'b1);
		repeat (4) send_tick(1'b0, 1'b1);
		settle();
		send_tick(1'b1, 1'b0);
		repeat (3) send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		settle();
		configure('{24'd2, 16'd0, 16'd3, 16'd0, 16'd2});
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		settle();
	endtask

	task automatic test_extremes();
		configure('{24'hFFFFFF, 16'd3, 16'd2, 16'd4, 16'd1});
		send_tick(1'b1, 1'b1);
		repeat (5) send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		settle();
		configure('{24'd1, 16'd1, 16'd0, 16'd1, 16'd9});
		send_tick(1'b1, 1'b1);
		repeat (2) send_tick(1'b0, 1'b1);
		settle();
	endtask

	task automatic test_hold_off();
		configure('{24'd6, 16'd3, 16'd2, 16'd4, 16'd5});
		hold_off_seq++;
		send_tick(1'b1, 1'b1);
		repeat (40) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		settle();
	endtask

	task automatic random_config();
		prts_pkg::cfg_t c;
		case ($urandom_range(9))
			0: c.extend_timeout = 24'($urandom_range(24'hFFFFFF, 1000));
			1: c.extend_timeout = 24'($urandom_range(200, 11));
			default: c.extend_timeout = 24'($urandom_range(10));
		endcase
		c.contact_hold = ($urandom_range(9) == 0) ? 16'($urandom_range(40))
			: 16'($urandom_range(5));
		c.brake_time = ($urandom_range(9) == 0) ? 16'($urandom_range(40))
			: 16'($urandom_range(5));
		c.retract_time = ($urandom_range(9) == 0) ? 16'($urandom_range(40))
			: 16'($urandom_range(5));
		c.abort_retract_time = ($urandom_range(9) == 0) ? 16'($urandom_range(40))
			: 16'($urandom_range(5));
		configure(c);
	endtask

	task automatic test_random(input int unsigned n_items);
		int unsigned contact_after;
		int unsigned open_run;
		int unsigned lim;
		logic start;
		logic level;
		logic was_extend;
		contact_after = 0;
		open_run = 0;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i % 150 == 0)
				random_config();
			if (seq_phase == prts_pkg::PH_IDLE) begin
				lim = (cfg_now.extend_timeout > 12) ? 12 : cfg_now.extend_timeout;
				contact_after = $urandom_range(lim + 2);
				open_run = 0;
				start = ($urandom_range(99) < 50);
			end else begin
				start = ($urandom_range(99) < 20);
			end
			was_extend = (seq_phase == prts_pkg::PH_EXTEND);
			if (was_extend) begin
				level = (open_run < contact_after);
				if ($urandom_range(99) < 5)
					level = ~level;
			end else begin
				level = 1'($urandom_range(1));
			end
			send_tick(start, level);
			if (was_extend)
				open_run++;
		end
		settle();
	endtask

	always @(posedge clk) begin
		if (hold_off_seq != hold_off_seen) begin
			hold_off_seen = hold_off_seq;
			hold_off_left = HOLD_OFF_CYCLES;
		end
		if (hold_off_left != 0) begin
			hold_off_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		prts_pkg::res_t got;
		prts_pkg::res_t want;
		string names[5];
		names = '{"drive_a", "drive_b", "busy_res", "done_res", "succeeded"};
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.drive_a, res_ch.drive_b, res_ch.busy_res, res_ch.done_res,
				res_ch.succeeded};
			if (pending_res.size() == 0) begin
				report_mismatch("result beat with no tick waiting for it");
			end else begin
				want = pending_res.pop_front();
				for (int i = 0; i < 5; i++)
					if (got[4-i] !== want[4-i])
						report_mismatch($sformatf("%s got %b want %b", names[i],
							got[4-i], want[4-i]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = prts_pkg::REG_EXTEND_TIMEOUT;
		cfg_wdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.start_req = 1'b0;
		tick_ch.detect_level = 1'b1;
		res_ch.ready = 1'b0;
		cfg_now = '{prts_pkg::RST_EXTEND_TIMEOUT, prts_pkg::RST_CONTACT_HOLD,
			prts_pkg::RST_BRAKE_TIME, prts_pkg::RST_RETRACT_TIME,
			prts_pkg::RST_ABORT_RETRACT_TIME};
		seq_phase = prts_pkg::PH_IDLE;
		seq_count = '0;
		seq_contact = 1'b0;
		hold_off_seq = 0;
		hold_off_seen = 0;
		hold_off_left = 0;
		cycle_cnt = 0;
		err_count = 0;
		send_idle_pct = 34;
		recv_idle_pct = 74;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_durations();
		test_extend_timeout();
		test_random(580);

		send_idle_pct = 74;
		recv_idle_pct = 34;
		test_hold_off();
		test_random(580);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_extremes();
		test_hold_off();
		test_random(590);

		quiesce();
		repeat (4) @(posedge clk);
		if (pending_res.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_res.size()));
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
sv/prts_pkg.sv
sv/prts_if.sv
sv/prts_cfg_regs.sv
sv/prts_step.sv
sv/push_rod_tap_sequencer.sv
verif/tb_push_rod_tap_sequencer.sv
